// ----- hw/rtl/humidity_temperature_frame_decoder_defines.svh -----
// assertion macros used by the frame decoder conversion module
`ifndef HUMIDITY_TEMPERATURE_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_TEMPERATURE_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, checked on every rising aclk edge outside reset
`define HTFD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising aclk edge outside reset
`define HTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/htfd_pkg.sv -----
package htfd_pkg;

    // configuration register indexes
    localparam logic CFG_IDX_CRC_POLY    = 1'b0;
    localparam logic CFG_IDX_TEMP_OFFSET = 1'b1;

    // frame status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BUS_ERR  = 2'd1;
    localparam logic [1:0] STATUS_TEMP_CRC = 2'd2;
    localparam logic [1:0] STATUS_HUMI_CRC = 2'd3;

    localparam logic [7:0] CRC_INIT       = 8'hFF;
    localparam logic [7:0] CRC_POLY_RESET = 8'h31;

    // fixed-point conversion factors, results scaled by 2^-16
    localparam int TEMP_SCALE = 17500;
    localparam int TEMP_BIAS  = 4500;
    localparam int HUMI_SCALE = 10000;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [15:0] raw_humi;
        logic [1:0]  status;
    } frame_result_t;

    // crc-8, msb first, one byte
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/htfd_frame.sv -----
module htfd_frame
    import htfd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [7:0]    crc_poly,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    rx_byte,
    input  logic          frame_start,
    input  logic          bus_error,
    output logic          res_valid,
    input  logic          res_ready,
    output frame_result_t res
);

    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic [2:0]    byte_position_reg, byte_position_next;
    logic [7:0]    running_crc_reg, running_crc_next;
    logic [15:0]   raw_temp_reg, raw_temp_next;
    logic [7:0]    humi_high_reg, humi_high_next;
    logic [7:0]    humi_low_reg, humi_low_next;
    logic [1:0]    pending_status_reg, pending_status_next;
    logic          res_valid_reg;
    frame_result_t res_reg, res_next;

    logic       accept;
    logic       done;
    logic [2:0] pos;
    logic [7:0] crc_cur;
    logic [7:0] crc_fed;
    logic [1:0] status_cur;

    assign in_ready  = !res_valid_reg || res_ready;
    assign accept    = in_valid && in_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb begin
        pos        = frame_start ? POS_T_MSB : byte_position_reg;
        if (pos > POS_H_CRC) begin
            pos = POS_T_MSB;
        end
        crc_cur    = frame_start ? CRC_INIT : running_crc_reg;
        status_cur = frame_start ? STATUS_OK : pending_status_reg;
        if (bus_error) begin
            status_cur = STATUS_BUS_ERR;
        end
        crc_fed = crc8_feed(crc_cur, rx_byte, crc_poly);

        byte_position_next  = pos + 3'd1;
        running_crc_next    = crc_fed;
        raw_temp_next       = raw_temp_reg;
        humi_high_next      = humi_high_reg;
        humi_low_next       = humi_low_reg;
        pending_status_next = status_cur;
        done                = 1'b0;

        case (pos)
            POS_T_MSB: begin
                raw_temp_next = {rx_byte, raw_temp_reg[7:0]};
            end
            POS_T_LSB: begin
                raw_temp_next = {raw_temp_reg[15:8], rx_byte};
            end
            POS_T_CRC: begin
                if (crc_cur != rx_byte && status_cur == STATUS_OK) begin
                    pending_status_next = STATUS_TEMP_CRC;
                end
                running_crc_next = CRC_INIT;
            end
            POS_H_MSB: begin
                humi_high_next = rx_byte;
            end
            POS_H_LSB: begin
                humi_low_next = rx_byte;
            end
            default: begin
                if (crc_cur != rx_byte && status_cur == STATUS_OK) begin
                    pending_status_next = STATUS_HUMI_CRC;
                end
                done                = 1'b1;
                byte_position_next  = POS_T_MSB;
                running_crc_next    = CRC_INIT;
            end
        endcase

        res_next.raw_temp = raw_temp_reg;
        res_next.raw_humi = {humi_high_reg, humi_low_reg};
        res_next.status   = pending_status_next;
        if (done) begin
            pending_status_next = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg  <= POS_T_MSB;
            running_crc_reg    <= CRC_INIT;
            raw_temp_reg       <= '0;
            humi_high_reg      <= '0;
            humi_low_reg       <= '0;
            pending_status_reg <= STATUS_OK;
            res_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                byte_position_reg  <= byte_position_next;
                running_crc_reg    <= running_crc_next;
                raw_temp_reg       <= raw_temp_next;
                humi_high_reg      <= humi_high_next;
                humi_low_reg       <= humi_low_next;
                pending_status_reg <= pending_status_next;
            end
            if (accept && done) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && done) begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- hw/rtl/htfd_convert.sv -----
module htfd_convert
    import htfd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [11:0]   temp_offset,
    input  logic          in_valid,
    output logic          in_ready,
    input  frame_result_t in_res,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [14:0]   temperature_centi,
    output logic [13:0]   humidity_centi,
    output logic [1:0]    frame_status
);

`include "humidity_temperature_frame_decoder_defines.svh"

    logic        out_valid_reg;
    logic [14:0] temp_reg, temp_next;
    logic [13:0] humi_reg, humi_next;
    logic [1:0]  status_reg;

    logic        accept;
    logic [30:0] temp_prod;
    logic [29:0] humi_prod;
    logic [16:0] temp_full;

    assign in_ready          = !out_valid_reg || out_ready;
    assign accept            = in_valid && in_ready;
    assign out_valid         = out_valid_reg;
    assign temperature_centi = temp_reg;
    assign humidity_centi    = humi_reg;
    assign frame_status      = status_reg;

    always_comb begin
        temp_prod = 31'(TEMP_SCALE) * {15'd0, in_res.raw_temp};
        humi_prod = 30'(HUMI_SCALE) * {14'd0, in_res.raw_humi};
        // floor(scaled) - bias - offset, wraps to the 15-bit field
        temp_full = {2'b00, temp_prod[30:16]} - 17'(TEMP_BIAS)
                    - {{5{temp_offset[11]}}, temp_offset};
        if (in_res.status == STATUS_OK) begin
            temp_next = temp_full[14:0];
            humi_next = humi_prod[29:16];
        end else begin
            temp_next = '0;
            humi_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            temp_reg   <= temp_next;
            humi_reg   <= humi_next;
            status_reg <= in_res.status;
        end
    end

    `HTFD_ASSERT_SAME(a_fail_zero, out_valid_reg && status_reg != STATUS_OK, temp_reg == 15'd0 && humi_reg == 14'd0, "failed frame carries nonzero data")
    `HTFD_ASSERT_NEXT(a_accept_fills, accept, out_valid_reg, "accepted frame did not reach output")
    `HTFD_ASSERT_SAME(a_humi_range, out_valid_reg, humi_reg < 14'd10000, "humidity above full scale")

endmodule

// ----- hw/rtl/humidity_temperature_frame_decoder.sv -----
// humidity/temperature sensor frame decoder
//
// input stream: one received sensor byte per request on s_tdata, in read order
// temperature msb, lsb, crc, humidity msb, lsb, crc. s_tuser[0] marks the
// first byte of a frame and realigns the byte counter; s_tuser[1] flags a
// missing acknowledge on that byte. without start marks bytes count modulo six.
// output stream: one request per six-byte frame with temperature in 0.01 degC,
// humidity in 0.01 %rh and a status in m_tuser (ok, or bus error, temperature
// crc error, humidity crc error, in that priority). failed frames give zeros.
// throughput: one byte per cycle unless s_tready is held low by a stall. a
// taken sixth byte goes through the crc/frame register, then the conversion
// register with its two multipliers, before the result request is valid.
// stall: each stage is a register slice; a stalled m_tready holds the result
// and backs up to s_tready only when both stages are full.
// reset (aresetn low, synchronous): polynomial back to 0x31, offset to zero,
// byte counter to the first position, crc to 0xff, no result pending.
// configuration: cfg_we writes cfg_wdata to register cfg_index (0 polynomial, 1 temperature
// offset); the user must write only while the block is idle, which the block does not enforce.
module humidity_temperature_frame_decoder
    import htfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_wdata,
    // byte input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [0] frame_start, [1] bus_error
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi, rest zero
    output logic [1:0]  m_tuser    // [1:0] frame_status
);

    logic [7:0]  crc_poly_reg;
    logic [11:0] temp_offset_reg;

    // frame stage to conversion stage
    logic          frm_valid;
    logic          frm_ready;
    frame_result_t frm_res;

    logic [14:0] temperature_centi;
    logic [13:0] humidity_centi;
    logic [1:0]  frame_status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_poly_reg    <= CRC_POLY_RESET;
            temp_offset_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IDX_CRC_POLY:    crc_poly_reg    <= cfg_wdata[7:0];
                CFG_IDX_TEMP_OFFSET: temp_offset_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // byte tracking, crc check and error priority
    htfd_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .crc_poly    (crc_poly_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser[0]),
        .bus_error   (s_tuser[1]),
        .res_valid   (frm_valid),
        .res_ready   (frm_ready),
        .res         (frm_res)
    );

    // fixed-point scaling into output register
    htfd_convert u_convert (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .temp_offset       (temp_offset_reg),
        .in_valid          (frm_valid),
        .in_ready          (frm_ready),
        .in_res            (frm_res),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .frame_status      (frame_status)
    );

    assign m_tdata = {3'b000, humidity_centi, temperature_centi};
    assign m_tuser = frame_status;

endmodule
